// ===== rtl/tpa_pkg.sv =====
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types and constants of the triangle primitive assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package tpa_pkg;

	// Default widths and depths
	localparam int TPA_INDEX_WIDTH = 32;
	localparam int TPA_QUEUE_DEPTH = 2;
	localparam int TPA_FIELD_WIDTH = 32;
	localparam int TPA_CFG_INDEX_WIDTH = 1;

	// Configuration register indexes
	localparam logic [TPA_CFG_INDEX_WIDTH-1:0] CFG_PRIMITIVE_MODE = 1'd0;
	localparam logic [TPA_CFG_INDEX_WIDTH-1:0] CFG_VERTEX_COUNT = 1'd1;

	// Primitive topology codes
	typedef enum logic [1:0] {
		MODE_LIST   = 2'd0,
		MODE_STRIP  = 2'd1,
		MODE_FAN    = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Batch status codes
	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_RANGE = 3'd1,
		ST_SHORT = 3'd2,
		ST_NOT3  = 3'd3,
		ST_MODE  = 3'd4
	} status_t;

	// Input request: one vertex index
	typedef struct packed {
		logic [TPA_FIELD_WIDTH-1:0] index_value;
		logic                       last_index;
	} tpa_in_t;

	// Output request: one result per index
	typedef struct packed {
		logic                       tri_valid;
		logic [TPA_FIELD_WIDTH-1:0] corner_a;
		logic [TPA_FIELD_WIDTH-1:0] corner_b;
		logic [TPA_FIELD_WIDTH-1:0] corner_c;
		logic                       batch_done;
		logic [2:0]                 batch_status;
	} tpa_out_t;

	// Queue status seen by the input stall and the back
	typedef struct packed {
		logic full;
		logic empty;
	} tpa_q_status_t;

endpackage : tpa_pkg

`default_nettype wire

// ===== rtl/triangle_primitive_assembler.sv =====
// ----------------------------------------------------------------------------
// triangle_primitive_assembler
// Turns a stream of vertex indices (list, strip or fan) into triangles with a
// per-batch status on the last index.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------
//   in      | input     | in_valid / in_stall  | tpa_in_t  in_item
//   out     | output    | out_valid / out_stall| tpa_out_t out_item
//   cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One index is accepted per cycle while in_stall is low; the front holds all
// batch state in registers and classifies an index in the cycle it is accepted.
// A result is written into the queue when its index is taken, then moves to
// the output register, and it waits in the queue while the output is stalled.
// in_stall rises only when the result queue (QUEUE_DEPTH entries) is full;
// out_stall holds the output register while the front keeps filling the queue.
// Reset empties the queue, clears batch state, mode to list, vertex count to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_primitive_assembler #(
	parameter int INDEX_WIDTH = tpa_pkg::TPA_INDEX_WIDTH,
	parameter int QUEUE_DEPTH = tpa_pkg::TPA_QUEUE_DEPTH
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire tpa_pkg::tpa_in_t                        in_item,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output tpa_pkg::tpa_out_t                            out_item,
	input  wire logic                                    cfg_write,
	input  wire logic [tpa_pkg::TPA_CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [tpa_pkg::TPA_FIELD_WIDTH-1:0]     cfg_data
);

	import tpa_pkg::*;

	tpa_q_status_t q_status;
	tpa_out_t      front_result;
	tpa_out_t      q_head;
	logic          push;
	logic          pop;

	// Accept while the queue has room
	assign in_stall = q_status.full;
	assign push     = in_valid && !in_stall;

	tpa_front #(
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.item      (in_item),
		.result    (front_result)
	);

	tpa_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_result),
		.pop       (pop),
		.head      (q_head),
		.status    (q_status)
	);

	tpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head      (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule : triangle_primitive_assembler

`default_nettype wire

// ===== rtl/tpa_front.sv =====
// ----------------------------------------------------------------------------
// tpa_front
// Accepts vertex indices, range-checks them, tracks batch state and builds
// one result per index (triangle and batch status).
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_front #(
	parameter int INDEX_WIDTH = tpa_pkg::TPA_INDEX_WIDTH
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write,
	input  wire logic [tpa_pkg::TPA_CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [tpa_pkg::TPA_FIELD_WIDTH-1:0]    cfg_data,
	input  wire logic                                   push,
	input  wire tpa_pkg::tpa_in_t                       item,
	output tpa_pkg::tpa_out_t                           result
);

	import tpa_pkg::*;

	localparam logic [TPA_FIELD_WIDTH:0]   IdxLimit = (TPA_FIELD_WIDTH+1)'(1) << INDEX_WIDTH;
	localparam logic [TPA_FIELD_WIDTH-1:0] IdxMask = IdxLimit[TPA_FIELD_WIDTH-1:0] -
		TPA_FIELD_WIDTH'(1);

	// Configuration registers
	mode_t                      mode_q;
	logic [TPA_FIELD_WIDTH-1:0] vcount_q;

	// Batch state
	logic [INDEX_WIDTH-1:0]     older_q;
	logic [INDEX_WIDTH-1:0]     newer_q;
	logic [INDEX_WIDTH-1:0]     first_q;
	logic [TPA_FIELD_WIDTH-1:0] count_q;
	logic [1:0]                 mod3_q;
	logic                       sticky_q;

	logic [TPA_FIELD_WIDTH-1:0] v_full;
	logic [INDEX_WIDTH-1:0]     v;
	logic                       range_bad;
	logic                       err_now;
	logic                       past_two;
	logic                       saturated;
	logic [TPA_FIELD_WIDTH-1:0] count_next;
	logic [1:0]                 mod3_next;
	logic                       emit;
	logic [INDEX_WIDTH-1:0]     ca;
	logic [INDEX_WIDTH-1:0]     cb;
	logic [INDEX_WIDTH-1:0]     cc;
	status_t                    status;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LIST;
			vcount_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PRIMITIVE_MODE: mode_q   <= mode_t'(cfg_data[1:0]);
				CFG_VERTEX_COUNT:   vcount_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	// Check range and derive counter conditions
	assign v_full     = item.index_value;
	assign v          = v_full[INDEX_WIDTH-1:0];
	assign range_bad  = (|(v_full & ~IdxMask)) || (v_full >= vcount_q);
	assign err_now    = sticky_q || range_bad;
	assign past_two   = |count_q[TPA_FIELD_WIDTH-1:1];
	assign saturated  = &count_q;
	assign count_next = saturated ? count_q : count_q + TPA_FIELD_WIDTH'(1);

	always_comb begin
		mod3_next = mod3_q;
		if (!saturated) begin
			mod3_next = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
		end
	end

	// Classify the index and pick corners
	always_comb begin
		emit = 1'b0;
		ca   = older_q;
		cb   = newer_q;
		cc   = v;
		if (!err_now) begin
			unique case (mode_q)
				MODE_LIST: begin
					emit = !saturated && (mod3_q == 2'd2);
				end
				MODE_STRIP: begin
					emit = past_two && (older_q != newer_q) && (newer_q != v) &&
						(older_q != v);
					if (count_q[0]) begin
						ca = newer_q;
						cb = older_q;
					end
				end
				MODE_FAN: begin
					ca   = first_q;
					emit = past_two && (first_q != newer_q) && (newer_q != v) &&
						(first_q != v);
				end
				MODE_NONE: begin
					emit = 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Status of the final index
	always_comb begin
		status = ST_OK;
		if (item.last_index) begin
			if (err_now) begin
				status = ST_RANGE;
			end else if (mode_q == MODE_NONE) begin
				status = ST_MODE;
			end else if (mode_q == MODE_LIST) begin
				status = (mod3_next != 2'd0) ? ST_NOT3 : ST_OK;
			end else begin
				status = past_two ? ST_OK : ST_SHORT;
			end
		end
	end

	// Assemble the result request
	always_comb begin
		result.tri_valid    = emit;
		result.corner_a     = emit ? TPA_FIELD_WIDTH'(ca) : '0;
		result.corner_b     = emit ? TPA_FIELD_WIDTH'(cb) : '0;
		result.corner_c     = emit ? TPA_FIELD_WIDTH'(cc) : '0;
		result.batch_done   = item.last_index;
		result.batch_status = status;
	end

	// Advance batch state; clear it at the end of a batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q  <= '0;
			newer_q  <= '0;
			first_q  <= '0;
			count_q  <= '0;
			mod3_q   <= '0;
			sticky_q <= 1'b0;
		end else if (push) begin
			if (item.last_index) begin
				older_q  <= '0;
				newer_q  <= '0;
				first_q  <= '0;
				count_q  <= '0;
				mod3_q   <= '0;
				sticky_q <= 1'b0;
			end else begin
				if (count_q == '0) begin
					first_q <= v;
				end
				older_q  <= newer_q;
				newer_q  <= v;
				count_q  <= count_next;
				mod3_q   <= mod3_next;
				sticky_q <= err_now;
			end
		end
	end

endmodule : tpa_front

`default_nettype wire

// ===== rtl/tpa_queue.sv =====
// ----------------------------------------------------------------------------
// tpa_queue
// Small result queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_queue #(
	parameter int QUEUE_DEPTH = tpa_pkg::TPA_QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tpa_pkg::tpa_out_t  push_data,
	input  wire logic               pop,
	output tpa_pkg::tpa_out_t       head,
	output tpa_pkg::tpa_q_status_t  status
);

	import tpa_pkg::*;

	localparam int PtrWidth = $clog2(QUEUE_DEPTH);
	localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

	tpa_out_t              entry_q [QUEUE_DEPTH];
	logic [PtrWidth-1:0]   wr_ptr_q;
	logic [PtrWidth-1:0]   rd_ptr_q;
	logic [CntWidth-1:0]   count_q;

	assign status.full  = (count_q == CntWidth'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = entry_q[rd_ptr_q];

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrWidth'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrWidth'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntWidth'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntWidth'(1);
			end
		end
	end

endmodule : tpa_queue

`default_nettype wire

// ===== rtl/tpa_back.sv =====
// ----------------------------------------------------------------------------
// tpa_back
// Drains the result queue into the output register and presents it.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tpa_pkg::tpa_q_status_t q_status,
	input  wire tpa_pkg::tpa_out_t  head,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output tpa_pkg::tpa_out_t       out_item
);

	import tpa_pkg::*;

	logic     valid_q;
	tpa_out_t data_q;

	// Pop when the output register is free or being taken
	assign pop       = !q_status.empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_item  = data_q;

	// Hold valid until the request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Load payload on pop
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head;
		end
	end

endmodule : tpa_back

`default_nettype wire

// ===== rtl/tpa_checker.sv =====
// ----------------------------------------------------------------------------
// tpa_checker
// Port-level checks of the triangle primitive assembler, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire tpa_pkg::tpa_out_t  out_item
);

	import tpa_pkg::*;

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("output changed while stalled");

	// Status only on the final index of a batch
	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.batch_done |-> out_item.batch_status == ST_OK)
		else $error("status reported before end of batch");

	// A range error suppresses the triangle
	a_range_no_tri: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.batch_status == ST_RANGE |-> !out_item.tri_valid)
		else $error("triangle emitted with range error");

	// Corners are zero without a triangle
	a_zero_corners: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.tri_valid |->
			out_item.corner_a == '0 && out_item.corner_b == '0 &&
			out_item.corner_c == '0)
		else $error("corners set without a triangle");

endmodule : tpa_checker

bind triangle_primitive_assembler tpa_checker u_tpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

`default_nettype wire

// ===== tb/sv/tb_triangle_primitive_assembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_primitive_assembler
// Self-checking bench for the triangle primitive assembler. A queue of
// vertex-index requests feeds a clocked driver. Every accepted index runs
// through a local assembler model, and the model's result waits in a queue
// until the monitor takes the block's result and compares it field by field.
// Both sides idle in random bursts. The receiver holds off once for a long
// stretch. List, strip, fan and unsupported modes all run, and the vertex
// count goes through its extremes between phases.
// ----------------------------------------------------------------------------

module tb_triangle_primitive_assembler;

	import tpa_pkg::*;

	localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          LONG_HOLD   = 80;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	tpa_in_t  in_item = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	tpa_out_t out_item;
	logic     cfg_write = 1'b0;
	logic [TPA_CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [TPA_FIELD_WIDTH-1:0]     cfg_data = '0;

	// Requests waiting for the driver, and model results waiting for the monitor
	tpa_in_t  pending_indices[$];
	tpa_out_t expected_triangles[$];
	int       indices_in_flight = 0;
	int       mismatch_count = 0;
	tpa_out_t want_result;

	// Idle control shared by driver, monitor and sequencer
	bit quiet = 1'b0;
	bit long_hold_req = 1'b0;
	bit hold_active = 1'b0;
	int gap_left = 0;
	int calm_left = 0;
	int stall_left = 0;

	// Model copy of the configuration and batch state
	mode_t       mode_shadow = MODE_LIST;
	logic [31:0] vcount_shadow = '0;
	logic [31:0] older_idx = '0;
	logic [31:0] newer_idx = '0;
	logic [31:0] fan_anchor = '0;
	logic [31:0] seen_count = '0;
	bit          range_fault = 1'b0;

	triangle_primitive_assembler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Assemble one index into a triangle and a batch status
	function automatic tpa_out_t assemble_triangle(input tpa_in_t req);
		tpa_out_t    res;
		logic [31:0] v;
		logic [31:0] p;
		logic [31:0] n;
		res = '0;
		v = req.index_value;
		p = seen_count;
		if (v >= vcount_shadow)
			range_fault = 1'b1;
		if (!range_fault) begin
			case (mode_shadow)
				MODE_LIST: begin
					if (p != COUNT_MAX && (p % 3) == 2) begin
						res.tri_valid = 1'b1;
						res.corner_a = older_idx;
						res.corner_b = newer_idx;
						res.corner_c = v;
					end
				end
				MODE_STRIP: begin
					if (p >= 2 && older_idx != newer_idx && newer_idx != v
							&& older_idx != v) begin
						res.tri_valid = 1'b1;
						// swap the leading corners on odd triangles
						res.corner_a = p[0] ? newer_idx : older_idx;
						res.corner_b = p[0] ? older_idx : newer_idx;
						res.corner_c = v;
					end
				end
				MODE_FAN: begin
					if (p >= 2 && fan_anchor != newer_idx && newer_idx != v
							&& fan_anchor != v) begin
						res.tri_valid = 1'b1;
						res.corner_a = fan_anchor;
						res.corner_b = newer_idx;
						res.corner_c = v;
					end
				end
				default: ;
			endcase
		end
		if (p == 0)
			fan_anchor = v;
		older_idx = newer_idx;
		newer_idx = v;
		if (seen_count != COUNT_MAX)
			seen_count = seen_count + 1;
		res.batch_done = req.last_index;
		if (req.last_index) begin
			n = seen_count;
			if (range_fault)
				res.batch_status = ST_RANGE;
			else if (mode_shadow == MODE_NONE)
				res.batch_status = ST_MODE;
			else if (mode_shadow == MODE_LIST)
				res.batch_status = ((n % 3) != 0) ? ST_NOT3 : ST_OK;
			else
				res.batch_status = (n < 3) ? ST_SHORT : ST_OK;
			older_idx = '0;
			newer_idx = '0;
			fan_anchor = '0;
			seen_count = '0;
			range_fault = 1'b0;
		end
		return res;
	endfunction

	// Draw an index: mostly in range, often from a small pool to force repeats
	function automatic logic [31:0] pick_index(input logic [31:0] vc);
		longint unsigned span;
		int unsigned     r;
		r = $urandom_range(0, 99);
		if (vc == 0 || r < 5) begin
			span = 64'h1_0000_0000 - {32'b0, vc};
			return vc + 32'({32'b0, $urandom} % span);
		end
		if (r < 35)
			return $urandom_range(0, (vc < 8) ? vc - 1 : 7);
		return 32'({32'b0, $urandom} % {32'b0, vc});
	endfunction

	task automatic push_index(input logic [31:0] value, input bit last);
		tpa_in_t req;
		req.index_value = value;
		req.last_index = last;
		pending_indices = {pending_indices, req};
		indices_in_flight++;
	endtask

	// Hold until every request is accepted and every result has arrived
	task automatic wait_drained();
		while (indices_in_flight != 0 || expected_triangles.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [TPA_CFG_INDEX_WIDTH-1:0] idx,
			input logic [31:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_config(input mode_t m, input logic [31:0] vc);
		wait_drained();
		write_reg(CFG_PRIMITIVE_MODE, {30'b0, m});
		mode_shadow = m;
		write_reg(CFG_VERTEX_COUNT, vc);
		vcount_shadow = vc;
	endtask

	// Fill one phase with batches, some cut short or padded to break the count
	task automatic random_phase(input int n_items);
		int count;
		int len;
		int r;
		count = 0;
		while (count < n_items) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				len = $urandom_range(1, 2);
			else if (mode_shadow == MODE_LIST)
				len = 3 * $urandom_range(1, 5) + ((r == 1) ? $urandom_range(1, 2) : 0);
			else
				len = $urandom_range(3, 14);
			for (int k = 0; k < len; k++)
				push_index(pick_index(vcount_shadow), k == len - 1);
			count += len;
		end
		// leave a batch open now and then so the next setting lands mid-batch
		if ($urandom_range(0, 3) == 0) begin
			len = $urandom_range(1, 2);
			for (int k = 0; k < len; k++)
				push_index(pick_index(vcount_shadow), 1'b0);
		end
	endtask

	// Offer requests; hold the payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_triangles = {expected_triangles, assemble_triangle(in_item)};
				indices_in_flight--;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_indices.size() != 0) begin
					in_item <= pending_indices.pop_front();
					in_valid <= 1'b1;
					if (calm_left != 0)
						calm_left--;
					else if (!quiet && $urandom_range(0, 49) == 0)
						calm_left = $urandom_range(20, 80);
					else if (!quiet && $urandom_range(0, 7) == 0)
						gap_left = $urandom_range(1, 16);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Hold the receiver off once for a long stretch while requests keep coming
	initial begin
		wait (long_hold_req);
		@(negedge clk);
		hold_active = 1'b1;
		repeat (LONG_HOLD) @(negedge clk);
		hold_active = 1'b0;
		long_hold_req = 1'b0;
	end

	// Check each result against the oldest prediction and pick the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_triangles.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: v=%0d a=%h b=%h c=%h done=%0d st=%0d",
							out_item.tri_valid, out_item.corner_a, out_item.corner_b,
							out_item.corner_c, out_item.batch_done, out_item.batch_status);
				end else begin
					want_result = expected_triangles.pop_front();
					if (out_item.tri_valid !== want_result.tri_valid
							|| out_item.corner_a !== want_result.corner_a
							|| out_item.corner_b !== want_result.corner_b
							|| out_item.corner_c !== want_result.corner_c
							|| out_item.batch_done !== want_result.batch_done
							|| out_item.batch_status !== want_result.batch_status) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("mismatch: want v=%0d a=%h b=%h c=%h done=%0d st=%0d",
								want_result.tri_valid, want_result.corner_a,
								want_result.corner_b, want_result.corner_c,
								want_result.batch_done, want_result.batch_status);
							$display("          got  v=%0d a=%h b=%h c=%h done=%0d st=%0d",
								out_item.tri_valid, out_item.corner_a, out_item.corner_b,
								out_item.corner_c, out_item.batch_done, out_item.batch_status);
						end
					end
				end
			end
			if (hold_active) begin
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 15);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Abort a hung run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	// Sequence directed and random phases
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// list: full triangle, ragged count, sticky range error, single index
		set_config(MODE_LIST, 32'd16);
		push_index(32'd0, 1'b0);
		push_index(32'd1, 1'b0);
		push_index(32'd2, 1'b1);
		push_index(32'd3, 1'b0);
		push_index(32'd4, 1'b1);
		push_index(32'd16, 1'b0);
		push_index(32'd6, 1'b0);
		push_index(32'd7, 1'b1);
		push_index(32'd9, 1'b1);

		// strip: repeated index drops triangles, odd ones swap; short batch
		set_config(MODE_STRIP, 32'd16);
		push_index(32'd0, 1'b0);
		push_index(32'd1, 1'b0);
		push_index(32'd2, 1'b0);
		push_index(32'd3, 1'b0);
		push_index(32'd3, 1'b0);
		push_index(32'd4, 1'b0);
		push_index(32'd5, 1'b1);
		push_index(32'd1, 1'b0);
		push_index(32'd2, 1'b1);

		// fan: repeats of the anchor and of the neighbour
		set_config(MODE_FAN, 32'd16);
		push_index(32'd5, 1'b0);
		push_index(32'd6, 1'b0);
		push_index(32'd7, 1'b0);
		push_index(32'd5, 1'b0);
		push_index(32'd8, 1'b1);

		// unsupported mode, then an empty vertex range
		set_config(MODE_NONE, 32'd16);
		push_index(32'd1, 1'b0);
		push_index(32'd2, 1'b0);
		push_index(32'd3, 1'b1);
		set_config(MODE_LIST, 32'd0);
		push_index(32'd0, 1'b1);

		// widest vertex count: top index is still out of range
		set_config(MODE_STRIP, COUNT_MAX);
		push_index(32'hFFFF_FFFE, 1'b0);
		push_index(32'd0, 1'b0);
		push_index(32'hFFFF_FFFF, 1'b1);

		// mode switch in the middle of a batch
		set_config(MODE_STRIP, 32'd16);
		push_index(32'd1, 1'b0);
		push_index(32'd2, 1'b0);
		set_config(MODE_FAN, 32'd16);
		push_index(32'd3, 1'b0);
		push_index(32'd4, 1'b1);

		// random phases over assorted settings
		for (int ph = 0; ph < 14; ph++) begin
			logic [31:0] vc;
			mode_t       m;
			case ($urandom_range(0, 7))
				0: vc = '0;
				1: vc = $urandom_range(1, 3);
				2: vc = $urandom_range(4, 64);
				3: vc = COUNT_MAX;
				default: vc = $urandom;
			endcase
			m = ($urandom_range(0, 9) == 0) ? MODE_NONE : mode_t'($urandom_range(0, 2));
			if (ph == 13) begin
				m = MODE_STRIP;
				vc = COUNT_MAX;
			end
			set_config(m, vc);
			if (ph == 2)
				long_hold_req = 1'b1;
			if (ph == 13)
				quiet = 1'b1;
			random_phase(100);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_triangles.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tpa_pkg.sv
rtl/tpa_front.sv
rtl/tpa_queue.sv
rtl/tpa_back.sv
rtl/triangle_primitive_assembler.sv
rtl/tpa_checker.sv
tb/sv/tb_triangle_primitive_assembler.sv
